// ===== src/json_key_value_extractor_macros.svh =====
`ifndef JSON_KEY_VALUE_EXTRACTOR_MACROS_SVH
`define JSON_KEY_VALUE_EXTRACTOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define JKV_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define JKV_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== src/jkv_pkg.sv =====
package jkv_pkg;

  localparam int unsigned MAX_KEY_LEN    = 8;
  localparam int unsigned RES_FIFO_DEPTH = 4;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;

  typedef enum logic {
    CFG_KEY_LENGTH = 1'b0,
    CFG_KEY_BYTES  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_COLON,
    PH_SKIPWS,
    PH_STRING,
    PH_BARE,
    PH_WAIT
  } phase_e;

  typedef enum logic [1:0] {
    ST_STRING   = 2'd0,
    ST_BARE     = 2'd1,
    ST_NULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       done_res;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic [7:0] null_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0: c = 8'h6e;
      2'd1: c = 8'h75;
      2'd2: c = 8'h6c;
      2'd3: c = 8'h6c;
      default: c = 8'h6c;
    endcase
    return c;
  endfunction

endpackage

// ===== src/jkv_fifo.sv =====
module jkv_fifo #(
  parameter int unsigned Depth = jkv_pkg::RES_FIFO_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  jkv_pkg::push_t push_i,
  input  logic          pop_i,
  output jkv_pkg::res_t head_o,
  output logic          valid_o,
  output logic          room_o,
  output logic [$clog2(Depth+1)-1:0] fill_o
);

  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned FillW = $clog2(Depth+1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  jkv_pkg::res_t mem_q [Depth];
  logic [PtrW-1:0]  wp_q, wp_d, rp_q, rp_d, wp1, wp2;
  logic [FillW-1:0] fill_q, fill_d;

  assign wp1 = (wp_q == LastPtr) ? '0 : wp_q + 1'b1;
  assign wp2 = (wp1 == LastPtr) ? '0 : wp1 + 1'b1;

  always_comb begin
    case (push_i.n)
      2'd1:    wp_d = wp1;
      2'd2:    wp_d = wp2;
      default: wp_d = wp_q;
    endcase
    rp_d = rp_q;
    if (pop_i) begin
      rp_d = (rp_q == LastPtr) ? '0 : rp_q + 1'b1;
    end
    fill_d = fill_q + FillW'(push_i.n) - FillW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      fill_q <= '0;
    end else begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wp_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wp1] <= push_i.r1;
    end
  end

  assign head_o  = mem_q[rp_q];
  assign valid_o = (fill_q != '0);
  assign room_o  = (fill_q <= FillW'(Depth - 2));
  assign fill_o  = fill_q;

endmodule

// ===== src/jkv_core.sv =====
module jkv_core #(
  parameter int unsigned MaxKeyLen = jkv_pkg::MAX_KEY_LEN
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_write_i,
  input  logic           cfg_index_i,
  input  logic [63:0]    cfg_data_i,
  input  logic           fire_i,
  input  logic [7:0]     byte_i,
  input  logic           end_i,
  output jkv_pkg::push_t push_o
);

  localparam int unsigned WinDepth = MaxKeyLen + 2;
  localparam int unsigned LenW     = $clog2(MaxKeyLen + 1);
  localparam logic [3:0]  MaxLen   = 4'(MaxKeyLen);

  logic [3:0]  key_len_q;
  logic [63:0] key_bytes_q;

  logic [7:0] win_q [WinDepth];
  logic [7:0] win_d [WinDepth];
  logic [7:0] win_n [WinDepth];
  jkv_pkg::phase_e phase_q, phase_d;
  logic [2:0] cnt_q, cnt_d, cnt_upd;
  logic       null_q, null_d, null_upd;

  logic [3:0]      len_eff;
  logic [MaxKeyLen:0] hit_len;
  logic            key_hit;
  logic            ws, stop, bare_end;
  logic            has_byte, has_status, bare_byte;
  jkv_pkg::status_e st, bare_st_cur, bare_st_upd;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q   <= '0;
      key_bytes_q <= '0;
    end else if (cfg_write_i) begin
      case (cfg_index_i)
        jkv_pkg::CFG_KEY_LENGTH: key_len_q   <= cfg_data_i[3:0];
        jkv_pkg::CFG_KEY_BYTES:  key_bytes_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ws = (byte_i == jkv_pkg::CH_SPACE) || (byte_i == jkv_pkg::CH_TAB) ||
              (byte_i == jkv_pkg::CH_LF) || (byte_i == jkv_pkg::CH_CR);
  assign stop = (byte_i == jkv_pkg::CH_COMMA) || (byte_i == jkv_pkg::CH_RBRACE) ||
                (byte_i == jkv_pkg::CH_RBRACK);
  assign bare_end = stop || (byte_i == jkv_pkg::CH_SPACE) ||
                    (byte_i == jkv_pkg::CH_LF) || (byte_i == jkv_pkg::CH_CR);

  // shifted window and parallel compare for every key length
  always_comb begin
    win_n[0] = byte_i;
    for (int i = 1; i < WinDepth; i++) begin
      win_n[i] = win_q[i-1];
    end
    for (int l = 0; l <= MaxKeyLen; l++) begin
      hit_len[l] = (win_n[0] == jkv_pkg::CH_QUOTE) && (win_n[l+1] == jkv_pkg::CH_QUOTE);
      for (int i = 0; i < l; i++) begin
        if (win_n[l-i] != key_bytes_q[8*i +: 8]) begin
          hit_len[l] = 1'b0;
        end
      end
    end
  end

  assign len_eff = (key_len_q > MaxLen) ? MaxLen : key_len_q;
  assign key_hit = hit_len[len_eff[LenW-1:0]];

  // null prefix tracking
  assign cnt_upd  = (cnt_q < 3'd7) ? cnt_q + 3'd1 : cnt_q;
  assign null_upd = null_q &&
                    !((cnt_q < 3'd4) && (byte_i != jkv_pkg::null_char(cnt_q[1:0])));
  assign bare_st_cur = (cnt_q == 3'd4 && null_q) ? jkv_pkg::ST_NULL : jkv_pkg::ST_BARE;
  assign bare_st_upd = (cnt_upd == 3'd4 && null_upd) ? jkv_pkg::ST_NULL : jkv_pkg::ST_BARE;

  // output decode
  always_comb begin
    has_byte   = 1'b0;
    has_status = 1'b0;
    bare_byte  = 1'b0;
    st         = jkv_pkg::ST_NOTFOUND;
    case (phase_q)
      jkv_pkg::PH_SKIPWS: begin
        if (!ws && byte_i != jkv_pkg::CH_QUOTE) begin
          if (stop) begin
            has_status = 1'b1;
          end else begin
            has_byte  = 1'b1;
            bare_byte = 1'b1;
            if (end_i) begin
              has_status = 1'b1;
              st         = bare_st_upd;
            end
          end
        end
      end
      jkv_pkg::PH_STRING: begin
        if (byte_i == jkv_pkg::CH_QUOTE) begin
          has_status = 1'b1;
          st         = jkv_pkg::ST_STRING;
        end else begin
          has_byte = 1'b1;
          if (end_i) begin
            has_status = 1'b1;
          end
        end
      end
      jkv_pkg::PH_BARE: begin
        if (bare_end) begin
          has_status = 1'b1;
          st         = bare_st_cur;
        end else begin
          has_byte  = 1'b1;
          bare_byte = 1'b1;
          if (end_i) begin
            has_status = 1'b1;
            st         = bare_st_upd;
          end
        end
      end
      default: ;
    endcase
    if (end_i && !has_status && phase_q != jkv_pkg::PH_WAIT) begin
      has_status = 1'b1;
      st         = jkv_pkg::ST_NOTFOUND;
    end
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    win_d   = win_q;
    cnt_d   = cnt_q;
    null_d  = null_q;
    if (bare_byte) begin
      cnt_d  = cnt_upd;
      null_d = null_upd;
    end
    case (phase_q)
      jkv_pkg::PH_SEARCH: begin
        win_d = win_n;
        if (key_hit) begin
          phase_d = jkv_pkg::PH_COLON;
        end
      end
      jkv_pkg::PH_COLON: begin
        if (byte_i == jkv_pkg::CH_COLON) begin
          phase_d = jkv_pkg::PH_SKIPWS;
        end
      end
      jkv_pkg::PH_SKIPWS: begin
        if (!ws) begin
          if (byte_i == jkv_pkg::CH_QUOTE) begin
            phase_d = jkv_pkg::PH_STRING;
          end else begin
            phase_d = jkv_pkg::PH_BARE;
          end
        end
      end
      default: ;
    endcase
    if (has_status) begin
      phase_d = jkv_pkg::PH_WAIT;
    end
    if (end_i) begin
      phase_d = jkv_pkg::PH_SEARCH;
      cnt_d   = '0;
      null_d  = 1'b1;
      for (int i = 0; i < WinDepth; i++) begin
        win_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= jkv_pkg::PH_SEARCH;
      cnt_q   <= '0;
      null_q  <= 1'b1;
      for (int i = 0; i < WinDepth; i++) begin
        win_q[i] <= '0;
      end
    end else if (fire_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      null_q  <= null_d;
      win_q   <= win_d;
    end
  end

  // result requests, value byte always ahead of the status
  always_comb begin
    push_o.r1.value_byte = '0;
    push_o.r1.done_res   = 1'b1;
    push_o.r1.status     = st;
    if (has_byte) begin
      push_o.r0.value_byte = byte_i;
      push_o.r0.done_res   = 1'b0;
      push_o.r0.status     = jkv_pkg::ST_STRING;
    end else begin
      push_o.r0 = push_o.r1;
    end
    push_o.n = fire_i ? (2'(has_byte) + 2'(has_status)) : 2'd0;
  end

endmodule

// ===== src/json_key_value_extractor.sv =====
// channel | direction | handshake                 | payload
// s_axis  | in        | s_axis_tvalid_i/tready_o  | tdata doc_byte, tlast doc_end
// m_axis  | out       | m_axis_tvalid_o/tready_i  | tdata value_byte, tlast done_res,
//         |           |                           | tuser status
// cfg     | in        | cfg_valid_i/cfg_ready_o   | cfg_index_i, cfg_data_i
//
// one byte per cycle sustained while the result queue has room; a byte is held in the
// input register until it fires, then its results are written into the result queue
// a byte producing two results (value byte plus status) pushes both at once; the output sends them one after the other
// a held byte leaves the input register only while the four-entry result queue has at least two free slots
// reset clears configuration, window and phase; no clearing pass
module json_key_value_extractor #(
  parameter int unsigned MaxKeyLen = jkv_pkg::MAX_KEY_LEN
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] doc_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] value_byte
  output logic        m_axis_tlast_o,
  output logic [1:0]  m_axis_tuser_o,   // [1:0] status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  `include "json_key_value_extractor_macros.svh"

  localparam int unsigned Depth = jkv_pkg::RES_FIFO_DEPTH;
  localparam int unsigned FillW = $clog2(Depth + 1);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;
  logic       fire, room, pop;
  logic [FillW-1:0] fill;
  jkv_pkg::push_t push;
  jkv_pkg::res_t  head;

  assign fire            = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || fire;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_end_q  <= s_axis_tlast_i;
    end
  end

  jkv_core #(
    .MaxKeyLen (MaxKeyLen)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_write_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (fire),
    .byte_i      (in_byte_q),
    .end_i       (in_end_q),
    .push_o      (push)
  );

  assign pop = m_axis_tvalid_o && m_axis_tready_i;

  jkv_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (m_axis_tvalid_o),
    .room_o  (room),
    .fill_o  (fill)
  );

  assign m_axis_tdata_o = head.value_byte;
  assign m_axis_tlast_o = head.done_res;
  assign m_axis_tuser_o = head.status;

  `JKV_ASSERT_NOW(a_fill_bound, 1'b1, fill <= FillW'(Depth), "result queue overflow")
  `JKV_ASSERT_NOW(a_byte_status, m_axis_tvalid_o && !m_axis_tlast_o,
                  m_axis_tuser_o == jkv_pkg::ST_STRING, "value byte with nonzero status")
  `JKV_ASSERT_NOW(a_status_data, m_axis_tvalid_o && m_axis_tlast_o,
                  m_axis_tdata_o == 8'h00, "status result with nonzero data")
  `JKV_ASSERT_NEXT(a_in_hold, in_valid_q && !fire,
                   in_valid_q && $stable(in_byte_q) && $stable(in_end_q),
                   "stalled input register changed")

endmodule
